@@ rtl/mdrc_pkg.sv @@
// Package for the masked destination rule classifier.
// Holds field widths, function codes, the controller state type and the
// command and status structs. Depends on nothing.
package mdrc_pkg;

    localparam int MAX_RULES_DEF = 16;

    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 32;
    localparam int MASK_W     = 32;
    localparam int FLOW_W     = 32;
    localparam int NUM_W      = 16;
    localparam int PRIO_W     = 8;
    localparam int HIT_SLOT_W = 4;

    localparam int ENTRY_W      = ADDR_W + MASK_W + FLOW_W + NUM_W + PRIO_W;
    localparam int IN_TDATA_W   = 152;
    localparam int OUT_TDATA_W  = 64;
    localparam int OUT_FIELDS_W = 2 + HIT_SLOT_W + FLOW_W + NUM_W + PRIO_W;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_APPEND = 2'd0;
    localparam func_t FUNC_LOOKUP = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } ctrl_state_t;

    typedef struct packed
    {
        logic accept;
        logic scan_start;
        logic scan_step;
        logic load_out;
        logic out_hit;
    } dp_cmd_t;

    typedef struct packed
    {
        func_t func;
        logic  count_zero;
        logic  match;
        logic  last_slot;
        logic  out_free;
    } dp_status_t;

endpackage

@@ rtl/mdrc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module mdrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mdrc_datapath.sv @@
// Datapath: rule RAM, rule count, scan pointer, compare and result register.
// Depends on mdrc_pkg and mdrc_ram.
module mdrc_datapath
    import mdrc_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  func_t                  s_tuser,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  dp_cmd_t                cmd,
    output dp_status_t             stat
);

    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int SW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] rd_slot_reg, rd_slot_next;
    logic [ADDR_W-1:0] lookup_addr_reg, lookup_addr_next;
    logic out_valid_reg, out_valid_next;
    logic [OUT_FIELDS_W-1:0] out_data_reg, out_data_next;

    logic full;
    logic ram_we;
    logic [SW-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic [ADDR_W-1:0] rd_dest;
    logic [MASK_W-1:0] rd_mask;
    logic [FLOW_W-1:0] rd_flow;
    logic [NUM_W-1:0]  rd_num;
    logic [PRIO_W-1:0] rd_prio;

    logic                  res_status;
    logic [HIT_SLOT_W-1:0] res_slot;
    logic [FLOW_W-1:0]     res_flow;
    logic [NUM_W-1:0]      res_num;
    logic [PRIO_W-1:0]     res_prio;

    // s_tdata: address, mask, flow id, rule number, priority, lookup address
    assign ram_wdata = s_tdata[ENTRY_W-1:0];
    assign full      = (count_reg == CW'(MAX_RULES));
    assign ram_we    = cmd.accept && (s_tuser == FUNC_APPEND) && !full;
    assign ram_raddr = cmd.scan_step ? rd_slot_reg + SW'(1) : '0;

    mdrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RULES)
    ) u_rule_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[SW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign {rd_prio, rd_num, rd_flow, rd_mask, rd_dest} = ram_rdata;

    always_comb
    begin
        count_next       = count_reg;
        rd_slot_next     = rd_slot_reg;
        lookup_addr_next = lookup_addr_reg;
        if (cmd.accept)
        begin
            if (ram_we)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (s_tuser == FUNC_CLEAR)
            begin
                count_next = '0;
            end
            lookup_addr_next = s_tdata[IN_TDATA_W-1 -: ADDR_W];
        end
        if (cmd.scan_start)
        begin
            rd_slot_next = '0;
        end
        else if (cmd.scan_step)
        begin
            rd_slot_next = rd_slot_reg + SW'(1);
        end
    end

    always_comb
    begin
        res_status = cmd.accept && (s_tuser == FUNC_APPEND) && full;
        res_slot   = '0;
        res_flow   = '0;
        res_num    = '0;
        res_prio   = '0;
        if (cmd.out_hit)
        begin
            res_slot = HIT_SLOT_W'(rd_slot_reg);
            res_flow = rd_flow;
            res_num  = rd_num;
            res_prio = rd_prio;
        end
        out_data_next = cmd.load_out
            ? {res_prio, res_num, res_flow, res_slot, cmd.out_hit, res_status}
            : out_data_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg     <= rd_slot_next;
        lookup_addr_reg <= lookup_addr_next;
        out_data_reg    <= out_data_next;
    end

    assign stat.func       = s_tuser;
    assign stat.count_zero = (count_reg == '0);
    assign stat.match      = ((rd_dest & rd_mask) == (lookup_addr_reg & rd_mask));
    assign stat.last_slot  = ((CW'(rd_slot_reg) + CW'(1)) == count_reg);
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

@@ rtl/mdrc_ctrl.sv @@
// Controller FSM: input handshake, lookup scan sequencing, result loading.
// Depends on mdrc_pkg.
module mdrc_ctrl
    import mdrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t stat
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = stat.out_free;
                cmd.accept = s_tvalid && stat.out_free;
                if (cmd.accept)
                begin
                    if ((stat.func == FUNC_LOOKUP) && !stat.count_zero)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load_out = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stat.match)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_hit  = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (stat.last_slot)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/masked_dest_rule_classifier_core.sv @@
// Top level of the masked destination rule classifier.
// Depends on mdrc_pkg, mdrc_ctrl, mdrc_datapath (and mdrc_ram below it).
//
// Channel  Signals                          Item
// s        s_tvalid s_tready s_tdata s_tuser  rule / lookup / clear request
// m        m_tvalid m_tready m_tdata          status and hit result
//
// Append, clear and unused codes: result valid in the cycle after acceptance.
// Lookup: scans slots from slot 0 up to the first match or the rule count, one
// rule RAM read per cycle through the registered read port.
// Reset clears the rule count and the output valid; rule RAM is not cleared.
// A new item is taken only when the result register is empty or draining.
module masked_dest_rule_classifier_core
    import mdrc_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // rule_address, rule_mask, rule_flow_id, rule_number, rule_priority,
    // lookup_address
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // func
    input  logic [FUNC_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status, hit, hit_slot, hit_flow_id, hit_rule_number, hit_priority, pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    mdrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mdrc_datapath #(
        .MAX_RULES (MAX_RULES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

@@ sim/tb_masked_dest_rule_classifier_core.sv @@
// Testbench for masked_dest_rule_classifier_core: directed and random append,
// lookup and clear items, checked against a first-match rule table model.
// Depends on mdrc_pkg and the classifier RTL.
module tb_masked_dest_rule_classifier_core;
    import mdrc_pkg::*;

    localparam func_t FUNC_UNUSED   = 2'd3;
    localparam int    RANDOM_ITEMS  = 505;
    localparam int    CYCLE_LIMIT   = 400000;
    localparam int    DRAIN_CYCLES  = 3 * MAX_RULES_DEF + 10;
    localparam int    REPORT_LIMIT  = 10;

    typedef struct
    {
        func_t       func;
        logic [31:0] rule_addr;
        logic [31:0] rule_mask;
        logic [31:0] rule_flow;
        logic [15:0] rule_num;
        logic [7:0]  rule_prio;
        logic [31:0] lookup_addr;
    } cls_req_t;

    typedef struct
    {
        logic        status;
        logic        hit;
        logic [3:0]  slot;
        logic [31:0] flow;
        logic [15:0] num;
        logic [7:0]  prio;
    } cls_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // rule table model
    logic [31:0] tbl_dest [MAX_RULES_DEF];
    logic [31:0] tbl_mask [MAX_RULES_DEF];
    logic [31:0] tbl_flow [MAX_RULES_DEF];
    logic [15:0] tbl_num  [MAX_RULES_DEF];
    logic [7:0]  tbl_prio [MAX_RULES_DEF];
    int          tbl_count = 0;

    cls_result_t expected_results[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          random_sent = 0;
    bit          no_idle = 1'b0;
    int          rx_run = 0;

    masked_dest_rule_classifier_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic cls_result_t classify(cls_req_t req);
        cls_result_t res;
        res = '{default: '0};
        case (req.func)
            FUNC_APPEND:
            begin
                if (tbl_count < MAX_RULES_DEF)
                begin
                    tbl_dest[tbl_count] = req.rule_addr;
                    tbl_mask[tbl_count] = req.rule_mask;
                    tbl_flow[tbl_count] = req.rule_flow;
                    tbl_num[tbl_count]  = req.rule_num;
                    tbl_prio[tbl_count] = req.rule_prio;
                    tbl_count++;
                end
                else
                    res.status = 1'b1;
            end
            FUNC_LOOKUP:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if ((tbl_dest[i] & tbl_mask[i]) == (req.lookup_addr & tbl_mask[i]))
                    begin
                        res.hit  = 1'b1;
                        res.slot = i[3:0];
                        res.flow = tbl_flow[i];
                        res.num  = tbl_num[i];
                        res.prio = tbl_prio[i];
                        break;
                    end
                end
            end
            FUNC_CLEAR:
                tbl_count = 0;
            default:
                ;
        endcase
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with s_tvalid still high.
    task automatic send_item(cls_req_t req);
        int gap;
        gap = no_idle ? 0 : rand_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.func;
        s_tdata  <= {req.lookup_addr, req.rule_prio, req.rule_num,
                     req.rule_flow, req.rule_mask, req.rule_addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(classify(req));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
    endtask

    function automatic cls_req_t make_req(func_t f, logic [31:0] a, logic [31:0] m,
                                          logic [31:0] fl, logic [15:0] n,
                                          logic [7:0] p, logic [31:0] la);
        cls_req_t req;
        req.func        = f;
        req.rule_addr   = a;
        req.rule_mask   = m;
        req.rule_flow   = fl;
        req.rule_num    = n;
        req.rule_prio   = p;
        req.lookup_addr = la;
        return req;
    endfunction

    function automatic cls_req_t rand_req(func_t f);
        return make_req(f, $urandom, $urandom, $urandom, $urandom_range(0, 65535),
                        $urandom_range(0, 255), $urandom);
    endfunction

    function automatic logic [31:0] rand_mask();
        int kind;
        int len;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(0, 32);
        if (kind < 5)
            return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
        else if (kind < 7)
            return $urandom;
        else if (kind < 9)
            return 32'hFFFF_FFFF;
        else
            return 32'h0;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        cls_result_t exp_res;
        cls_result_t act;
        if (rst_n && m_tvalid && m_tready)
        begin
            act.status = m_tdata[0];
            act.hit    = m_tdata[1];
            act.slot   = m_tdata[5:2];
            act.flow   = m_tdata[37:6];
            act.num    = m_tdata[53:38];
            act.prio   = m_tdata[61:54];
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result item: tdata %h", m_tdata);
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (act.status !== exp_res.status || act.hit !== exp_res.hit ||
                    act.slot !== exp_res.slot || act.flow !== exp_res.flow ||
                    act.num !== exp_res.num || act.prio !== exp_res.prio)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: exp st %b hit %b slot %0d flow %h num %h",
                                  " prio %h / act st %b hit %b slot %0d flow %h num %h",
                                  " prio %h"},
                                 exp_res.status, exp_res.hit, exp_res.slot, exp_res.flow,
                                 exp_res.num, exp_res.prio, act.status, act.hit, act.slot,
                                 act.flow, act.num, act.prio);
                end
            end
        end
    end

    // result-side backpressure
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (no_idle)
                m_tready <= 1'b1;
            else if (rx_run > 0)
                rx_run--;
            else if (m_tready)
            begin
                m_tready <= 1'b0;
                rx_run = rand_gap();
            end
            else
            begin
                m_tready <= 1'b1;
                rx_run = $urandom_range(0, 12);
            end
        end
    end

    task automatic test_empty_and_unused();
        send_item(make_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, 32'h0));
        send_item(make_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, 32'hFFFF_FFFF));
        send_item(make_req(FUNC_UNUSED, '1, '1, '1, '1, '1, '1));
        send_item(make_req(FUNC_CLEAR, '1, '1, '1, '1, '1, '1));
    endtask

    task automatic test_extremes();
        send_item(make_req(FUNC_APPEND, '1, '1, '1, '1, '1, '0));
        send_item(make_req(FUNC_APPEND, '0, '0, '0, '0, '0, '1));
        send_item(make_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, 32'hFFFF_FFFF));
        send_item(make_req(FUNC_LOOKUP, '1, '1, '1, '1, '1, 32'h0));
        send_item(make_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, 32'h1234_5678));
        send_item(make_req(FUNC_CLEAR, '0, '0, '0, '0, '0, '0));
        send_item(make_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, 32'hFFFF_FFFF));
    endtask

    // fill every slot, overflow, hit the last slot, miss
    task automatic test_table_full();
        for (int i = 0; i < MAX_RULES_DEF; i++)
            send_item(make_req(FUNC_APPEND, 32'hA000_0000 | i, 32'hFFFF_FFFF, $urandom,
                               16'(i), 8'(i), '0));
        wait_drained();
        send_item(make_req(FUNC_APPEND, '1, '0, '1, '1, '1, '0));
        send_item(make_req(FUNC_LOOKUP, '0, '0, '0, '0, '0,
                           32'hA000_0000 | (MAX_RULES_DEF - 1)));
        send_item(make_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, 32'h5000_0000));
    endtask

    task automatic test_random_sessions();
        int n_rules;
        int n_lookups;
        int s;
        cls_req_t req;
        while (random_sent < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0)
            begin
                send_item(rand_req(FUNC_CLEAR));
                random_sent++;
            end
            n_rules = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 19)
                                                  : $urandom_range(1, 8);
            for (int i = 0; i < n_rules; i++)
            begin
                req = rand_req(FUNC_APPEND);
                req.rule_mask = rand_mask();
                send_item(req);
                random_sent++;
            end
            n_lookups = $urandom_range(4, 12);
            for (int i = 0; i < n_lookups; i++)
            begin
                req = rand_req(FUNC_LOOKUP);
                if (tbl_count > 0 && $urandom_range(0, 9) < 7)
                begin
                    s = $urandom_range(0, tbl_count - 1);
                    req.lookup_addr = (tbl_dest[s] & tbl_mask[s]) | ($urandom & ~tbl_mask[s]);
                end
                send_item(req);
                random_sent++;
                if ($urandom_range(0, 19) == 0)
                    send_item(rand_req(FUNC_UNUSED));
                if ($urandom_range(0, 29) == 0)
                begin
                    send_item(rand_req(func_t'($urandom_range(0, 2))));
                    random_sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_and_unused();
        test_extremes();
        test_table_full();
        test_random_sessions();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
        begin
            $display("mismatches: %0d, missing results: %0d", mismatch_count,
                     expected_results.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ masked_dest_rule_classifier_core.f @@
rtl/mdrc_pkg.sv
rtl/mdrc_ram.sv
rtl/mdrc_datapath.sv
rtl/mdrc_ctrl.sv
rtl/masked_dest_rule_classifier_core.sv
sim/tb_masked_dest_rule_classifier_core.sv
